// ===== hdl/mahd_pkg.sv =====
// shared types, tables and constants for the mpeg audio header decoder
package mahd_pkg;

	localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

	localparam int RECIP_SHIFT = 30;
	localparam int PROD_W      = 20;
	localparam int RECIP_W     = 26;
	localparam int LEN_W       = 12;

	// reciprocals scaled by 2^30, rounded up; exact floor for numerators below 2^20
	localparam logic [RECIP_W-1:0] RECIP_441 = 26'd2434789;
	localparam logic [RECIP_W-1:0] RECIP_48  = 26'd22369622;
	localparam logic [RECIP_W-1:0] RECIP_32  = 26'd33554432;

	typedef enum logic [1:0] {
		VER_25   = 2'd0,
		VER_RSVD = 2'd1,
		VER_2    = 2'd2,
		VER_1    = 2'd3
	} ver_t;

	typedef enum logic [1:0] {
		LAYER_RSVD = 2'd0,
		LAYER_III  = 2'd1,
		LAYER_II   = 2'd2,
		LAYER_I    = 2'd3
	} layer_t;

	typedef enum logic [1:0] {
		FAM_441 = 2'd0,
		FAM_480 = 2'd1,
		FAM_320 = 2'd2
	} fam_t;

	localparam logic [1:0] FRI_RSVD  = 2'd3;
	localparam logic [3:0] BRI_BAD   = 4'hF;
	localparam logic [1:0] CHM_MONO  = 2'd3;

	localparam logic [8:0] KBPS_TBL [3][2][16] = '{
		'{'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		  '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
		'{'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		  '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0}},
		'{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
		  '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}}
	};

	localparam logic [15:0] RATE_TBL [4][4] = '{
		'{16'd11025, 16'd12000, 16'd8000,  16'd0},
		'{16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd44100, 16'd48000, 16'd32000, 16'd0}
	};

	typedef struct packed {
		logic        ok;
		ver_t        ver;
		layer_t      lay;
		logic [3:0]  flags;
		logic        pad;
		logic [1:0]  chans;
		logic [1:0]  modex;
		logic [1:0]  emph;
		logic [8:0]  kbps;
		logic [15:0] rate;
		logic [12:0] coef;
		fam_t        fam;
	} dec_t;

endpackage

// ===== hdl/mpeg_audio_header_decoder_core.sv =====
// top level: four-stage pipelined mpeg audio frame header decoder
// an accepted header is registered in s1, s2 and s3 before the output register s4
// throughput: one item per cycle while out_stall is low; stages are decode, rate product,
// reciprocal multiply, length and limit check
// stalled stages hold while empty stages upstream keep filling
// reset empties the pipeline and sets max_frame_bytes to 2881
module mpeg_audio_header_decoder_core
	import mahd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] header_word,
	input  logic        max_frame_bytes_we,
	input  logic [11:0] max_frame_bytes_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_valid,
	output logic [1:0]  version_code,
	output logic [1:0]  layer_code,
	output logic [3:0]  flag_bits,
	output logic        padding_bit,
	output logic [1:0]  channel_count,
	output logic [1:0]  mode_extension,
	output logic [1:0]  emphasis_code,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] sample_rate_hz,
	output logic [11:0] frame_bytes
);

	dec_t dec_in;
	dec_t dec_s1, dec_s2, dec_s3, dec_s4;
	dec_t dec_f;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic [11:0] max_frame_bytes_q;
	logic [PROD_W-1:0] p_s2;
	logic [PROD_W+RECIP_W-1:0] prod_s3;
	logic [RECIP_W-1:0] recip;
	logic [21:0] p_full;
	logic [LEN_W-1:0] quot, sum;
	logic [LEN_W+1:0] len;
	logic ok_f;
	logic [11:0] len_s4;

	mahd_decode u_decode (
		.header_word (header_word),
		.dec         (dec_in)
	);

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= 12'd2881;
		end else if (max_frame_bytes_we) begin
			max_frame_bytes_q <= max_frame_bytes_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign p_full = 22'(dec_s1.kbps) * 22'(dec_s1.coef);

	always_comb begin
		case (dec_s2.fam)
			FAM_441: recip = RECIP_441;
			FAM_480: recip = RECIP_48;
			default: recip = RECIP_32;
		endcase
	end

	always_comb begin
		quot = prod_s3[RECIP_SHIFT +: LEN_W];
		sum  = quot + LEN_W'(dec_s3.pad);
		len  = (dec_s3.lay == LAYER_I) ? {sum, 2'b00} : {2'b00, sum};
		ok_f = dec_s3.ok && (len <= {2'b00, max_frame_bytes_q});
		dec_f    = dec_s3;
		dec_f.ok = ok_f;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dec_s1 <= dec_in;
		end
		if (en_s2) begin
			dec_s2 <= dec_s1;
			p_s2   <= p_full[PROD_W-1:0];
		end
		if (en_s3) begin
			dec_s3  <= dec_s2;
			prod_s3 <= (PROD_W+RECIP_W)'(p_s2) * (PROD_W+RECIP_W)'(recip);
		end
		if (en_s4) begin
			dec_s4 <= dec_f;
			len_s4 <= ok_f ? len[11:0] : 12'd0;
		end
	end

	assign out_valid      = v_s4;
	assign header_valid   = dec_s4.ok;
	assign version_code   = dec_s4.ver;
	assign layer_code     = dec_s4.lay;
	assign flag_bits      = dec_s4.flags;
	assign padding_bit    = dec_s4.pad;
	assign channel_count  = dec_s4.chans;
	assign mode_extension = dec_s4.modex;
	assign emphasis_code  = dec_s4.emph;
	assign bitrate_kbps   = dec_s4.ok ? dec_s4.kbps : 9'd0;
	assign sample_rate_hz = dec_s4.ok ? dec_s4.rate : 16'd0;
	assign frame_bytes    = len_s4;

endmodule

// ===== hdl/mahd_decode.sv =====
// header field split, validity checks, rate tables and length coefficient
module mahd_decode
	import mahd_pkg::*;
(
	input  logic [31:0] header_word,
	output dec_t        dec
);

	logic [1:0] lay_idx;
	logic [3:0] bri;
	logic [1:0] fri;
	logic [7:0] fact;
	logic [9:0] scaled;
	logic       hdr_ok;

	assign bri     = header_word[15:12];
	assign fri     = header_word[11:10];
	assign lay_idx = header_word[18:17] - 2'd1;

	always_comb begin
		dec.ver   = ver_t'(header_word[20:19]);
		dec.lay   = layer_t'(header_word[18:17]);
		dec.flags = {header_word[16], header_word[8], header_word[3], header_word[2]};
		dec.pad   = header_word[9];
		dec.chans = (header_word[7:6] == CHM_MONO) ? 2'd1 : 2'd2;
		dec.modex = header_word[5:4];
		dec.emph  = header_word[1:0];
		dec.kbps  = (lay_idx == 2'd3) ? 9'd0 : KBPS_TBL[lay_idx][header_word[19]][bri];
		dec.rate  = RATE_TBL[header_word[20:19]][fri];

		hdr_ok = ((header_word & SYNC_MASK) == SYNC_MASK) && (dec.lay != LAYER_RSVD)
			&& (dec.ver != VER_RSVD) && (bri != BRI_BAD) && (fri != FRI_RSVD);
		dec.ok = hdr_ok && (dec.kbps != 9'd0) && (dec.rate != 16'd0);

		if (dec.lay == LAYER_I) begin
			fact = 8'd12;
		end else if (dec.ver == VER_1 || dec.lay == LAYER_II) begin
			fact = 8'd144;
		end else begin
			fact = 8'd72;
		end

		case (dec.ver)
			VER_1:   scaled = {2'b00, fact};
			VER_2:   scaled = {1'b0, fact, 1'b0};
			default: scaled = {fact, 2'b00};
		endcase

		case (fri)
			2'd0: begin
				dec.fam  = FAM_441;
				dec.coef = {scaled, 3'b000} + {2'b00, scaled, 1'b0};
			end
			2'd1: begin
				dec.fam  = FAM_480;
				dec.coef = {3'b000, scaled};
			end
			default: begin
				dec.fam  = FAM_320;
				dec.coef = {3'b000, scaled};
			end
		endcase
	end

endmodule

// ===== hdl/mahd_checker.sv =====
// port-level checks for the mpeg audio header decoder and their bind
module mahd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        header_valid,
	input logic [1:0]  channel_count,
	input logic [8:0]  bitrate_kbps,
	input logic [15:0] sample_rate_hz,
	input logic [11:0] frame_bytes
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_valid)
			&& $stable(frame_bytes) && $stable(bitrate_kbps))
		else $error("stalled output item changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_valid |->
			bitrate_kbps == 9'd0 && sample_rate_hz == 16'd0 && frame_bytes == 12'd0)
		else $error("invalid header with nonzero rate or length");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_valid |->
			bitrate_kbps != 9'd0 && sample_rate_hz != 16'd0 && frame_bytes != 12'd0)
		else $error("valid header with zero rate or length");

	a_chans: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel_count == 2'd1 || channel_count == 2'd2)
		else $error("bad channel count");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

endmodule

bind mpeg_audio_header_decoder_core mahd_checker u_mahd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.header_valid   (header_valid),
	.channel_count  (channel_count),
	.bitrate_kbps   (bitrate_kbps),
	.sample_rate_hz (sample_rate_hz),
	.frame_bytes    (frame_bytes)
);
